// ----- rtl/core/vsb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vsb_pkg;

  // Palette geometry and fixed-point constants.
  localparam int MAX_BONES_DEF  = 64;
  localparam int WORDS_PER_BONE = 12;
  localparam int BONE_SLOTS     = 4;
  localparam logic signed [18:0] ONE_Q15 = 19'sd32768;
  localparam logic signed [52:0] ROUND_HALF = 53'sd16384;

  // Function code of a request.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SKIN  = 1'b1;

  // Request transaction: either a palette word or a vertex.
  typedef struct packed {
    logic        func;
    logic [31:0] bone_indices;
    logic [47:0] weights;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [47:0] normal_xyz;
    logic [31:0] texcoord;
    logic [9:0]  palette_address;
    logic signed [31:0] palette_value;
    logic        last_vertex;
  } req_t;

  // Result transaction: one skinned vertex.
  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic [47:0] out_normal_xyz;
    logic [31:0] out_texcoord;
    logic        out_last;
  } rsp_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
    logic signed [31:0] r;
    if (v > 53'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -53'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate a wide signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [52:0] v);
    logic signed [15:0] r;
    if (v > 53'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -53'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/vertex_skinning_blend.sv -----
// A vertex transaction passes through stage registers A to E and then the result register.
// Throughput: one transaction per cycle unless the result register is held; each bone slot
// has its own palette copy in twelve word banks, so all 48 matrix words are read at once.
// Palette writes give no result and take one slot of the pipeline.
// Reset (rst, synchronous) empties the pipeline and sets bones_per_vertex to two; the palette
// itself is not cleared and must be written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module vertex_skinning_blend #(
  parameter int MAX_BONES = vsb_pkg::MAX_BONES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_wdata,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire vsb_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output vsb_pkg::rsp_t      rsp
);

  localparam int BW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int NS = vsb_pkg::BONE_SLOTS;
  localparam int NW = vsb_pkg::WORDS_PER_BONE;

  // Configuration register.
  logic [2:0] bpv;
  always_ff @(posedge clk) begin
    if (rst) begin
      bpv <= 3'd2;
    end else if (cfg_we) begin
      bpv <= cfg_wdata;
    end
  end

  // The whole pipeline moves together unless the result register is held.
  logic en;
  assign en = !rsp_valid || rsp_ready;
  assign req_ready = en;

  // Constant tables: byte to bone number, and quarter address to bone.
  logic [BW-1:0] mod_tab [256];
  logic [6:0]    div3_tab [256];
  for (genvar i = 0; i < 256; i++) begin : g_tab
    assign mod_tab[i]  = BW'(i % MAX_BONES);
    assign div3_tab[i] = 7'(i / 3);
  end

  // Stage A: input register.
  vsb_pkg::req_t a;
  logic va;
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= req_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a <= req;
    end
  end

  // Palette address decode: bone is address / 12, word is the remainder.
  logic [6:0]    wr_q;
  logic [9:0]    wr_rem;
  logic [3:0]    wr_word;
  logic [BW-1:0] wr_bone;
  logic          wr_ok;
  logic [BW-1:0] rd_bone [NS];
  always_comb begin
    wr_q    = div3_tab[a.palette_address[9:2]];
    wr_rem  = a.palette_address - 10'(wr_q) * 10'(NW);
    wr_word = wr_rem[3:0];
    wr_bone = BW'(wr_q);
    wr_ok   = {2'b00, a.palette_address} < 12'(MAX_BONES * NW);
    for (int k = 0; k < NS; k++) begin
      rd_bone[k] = mod_tab[a.bone_indices[8*k +: 8]];
    end
  end

  // Palette memories: one copy per bone slot, one bank per matrix word.
  logic [31:0] pal_mem [NS][NW][MAX_BONES];
  logic [31:0] md [NS][NW];
  always_ff @(posedge clk) begin
    if (en && va && (a.func == vsb_pkg::FUNC_WRITE) && wr_ok) begin
      for (int k = 0; k < NS; k++) begin
        pal_mem[k][wr_word][wr_bone] <= a.palette_value;
      end
    end
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        for (int j = 0; j < NW; j++) begin
          md[k][j] <= pal_mem[k][j][rd_bone[k]];
        end
      end
    end
  end

  // Stage B: slot weights, complement on the last used slot (on slot 0 in two-bone mode).
  logic signed [18:0] lane [3];
  logic signed [18:0] w_next [NS];
  logic               u_next [NS];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane[i] = $signed({3'b000, a.weights[16*i +: 16]});
    end
    for (int k = 0; k < NS; k++) begin
      w_next[k] = '0;
      u_next[k] = 1'b0;
    end
    if (bpv >= 3'd4) begin
      w_next[0] = lane[0];
      w_next[1] = lane[1];
      w_next[2] = lane[2];
      w_next[3] = vsb_pkg::ONE_Q15 - lane[0] - lane[1] - lane[2];
      for (int k = 0; k < NS; k++) begin
        u_next[k] = 1'b1;
      end
    end else if (bpv == 3'd3) begin
      w_next[0] = lane[0];
      w_next[1] = lane[1];
      w_next[2] = vsb_pkg::ONE_Q15 - lane[0] - lane[1];
      u_next[0] = 1'b1;
      u_next[1] = 1'b1;
      u_next[2] = 1'b1;
    end else begin
      w_next[1] = lane[0];
      w_next[0] = vsb_pkg::ONE_Q15 - lane[0];
      u_next[0] = 1'b1;
      u_next[1] = 1'b1;
    end
  end

  logic               vb;
  logic signed [18:0] wb [NS];
  logic               ub [NS];
  logic signed [31:0] pb [3];
  logic signed [15:0] nb [3];
  logic [31:0]        tcb;
  logic               lb;
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va && (a.func == vsb_pkg::FUNC_SKIN);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      wb    <= w_next;
      ub    <= u_next;
      pb[0] <= a.pos_x;
      pb[1] <= a.pos_y;
      pb[2] <= a.pos_z;
      for (int i = 0; i < 3; i++) begin
        nb[i] <= $signed(a.normal_xyz[16*i +: 16]);
      end
      tcb   <= a.texcoord;
      lb    <= a.last_vertex;
    end
  end

  // Stage C: all matrix products, one multiplier per term.
  logic               vc;
  logic signed [63:0] pp [NS][3][3];
  logic signed [47:0] np [NS][3][3];
  logic signed [31:0] trc [NS][3];
  logic signed [18:0] wc [NS];
  logic               uc [NS];
  logic [31:0]        tcc;
  logic               lc;
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        for (int c = 0; c < 3; c++) begin
          for (int r = 0; r < 3; r++) begin
            pp[k][c][r] <= pb[r] * $signed(md[k][r*3 + c]);
            np[k][c][r] <= nb[r] * $signed(md[k][r*3 + c]);
          end
          trc[k][c] <= $signed(md[k][9 + c]);
        end
      end
      wc  <= wb;
      uc  <= ub;
      tcc <= tcb;
      lc  <= lb;
    end
  end

  // Stage D: per-bone transformed point and direction, saturated.
  logic               vd;
  logic signed [31:0] tp [NS][3];
  logic signed [31:0] tn [NS][3];
  logic signed [18:0] wd [NS];
  logic               ud [NS];
  logic [31:0]        tcd;
  logic               ld;
  logic signed [49:0] sp [NS][3];
  logic signed [49:0] sn [NS][3];
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      for (int c = 0; c < 3; c++) begin
        sp[k][c] = 50'(pp[k][c][0] >>> 16) + 50'(pp[k][c][1] >>> 16)
                 + 50'(pp[k][c][2] >>> 16) + 50'(trc[k][c]);
        sn[k][c] = (50'(np[k][c][0]) + 50'(np[k][c][1]) + 50'(np[k][c][2])) >>> 16;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        for (int c = 0; c < 3; c++) begin
          tp[k][c] <= vsb_pkg::sat32(53'(sp[k][c]));
          tn[k][c] <= vsb_pkg::sat32(53'(sn[k][c]));
        end
      end
      wd  <= wc;
      ud  <= uc;
      tcd <= tcc;
      ld  <= lc;
    end
  end

  // Stage E: weighted products; unused slots contribute nothing.
  logic               ve;
  logic signed [50:0] wp [NS][3];
  logic signed [50:0] wn [NS][3];
  logic [31:0]        tce;
  logic               le;
  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vd;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        for (int c = 0; c < 3; c++) begin
          wp[k][c] <= ud[k] ? tp[k][c] * wd[k] : 51'sd0;
          wn[k][c] <= ud[k] ? tn[k][c] * wd[k] : 51'sd0;
        end
      end
      tce <= tcd;
      le  <= ld;
    end
  end

  // Stage F: blend, round and saturate into the result register.
  logic signed [52:0] ap [3];
  logic signed [52:0] an [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ap[c] = (53'(wp[0][c]) + 53'(wp[1][c]) + 53'(wp[2][c]) + 53'(wp[3][c])
              + vsb_pkg::ROUND_HALF) >>> 15;
      an[c] = (53'(wn[0][c]) + 53'(wn[1][c]) + 53'(wn[2][c]) + 53'(wn[3][c])
              + vsb_pkg::ROUND_HALF) >>> 15;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= ve;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rsp.out_pos_x      <= vsb_pkg::sat32(ap[0]);
      rsp.out_pos_y      <= vsb_pkg::sat32(ap[1]);
      rsp.out_pos_z      <= vsb_pkg::sat32(ap[2]);
      rsp.out_normal_xyz <= {vsb_pkg::sat16(an[2]), vsb_pkg::sat16(an[1]),
                             vsb_pkg::sat16(an[0])};
      rsp.out_texcoord   <= tce;
      rsp.out_last       <= le;
    end
  end

  // The weights of a vertex always add up to one.
  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    vb |-> (21'(wb[0]) + 21'(wb[1]) + 21'(wb[2]) + 21'(wb[3]) == 21'sd32768))
    else $error("bone weights do not sum to one");

  // A palette write never enters the arithmetic stages.
  a_write_drops: assert property (@(posedge clk) disable iff (rst)
    (en && va && (a.func == vsb_pkg::FUNC_WRITE)) |=> !vb)
    else $error("palette write produced a vertex");

  // A vertex in stage C moves on to stage D when the pipeline advances.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (en && vc) |=> vd)
    else $error("vertex lost between stages");

  // While the result is held, the stages behind it hold as well.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(ve) && $stable(vd) && $stable(vb)))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ----- tb/vertex_skinning_blend_test.sv -----
`timescale 1ns / 1ps

module vertex_skinning_blend_test;

  localparam int NBONES = 64;
  localparam int PAL_WORDS = NBONES * 12;
  localparam int DRAIN_CYCLES = 10;

  // Expected skinned vertices and the palette/bone count they are computed from.
  class skin_scoreboard;
    int palette[PAL_WORDS];
    bit [2:0] bones_cfg = 3'd2;
    vsb_pkg::rsp_t skinned_q[$];
    int errors;
    int vertices_checked;
    int words_written;

    function void set_bones(bit [2:0] v);
      bones_cfg = v;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint word(int bone, int row, int col);
      return longint'(palette[bone * 12 + row * 3 + col]);
    endfunction

    // Update the palette, or work out the skinned vertex a transaction will produce.
    function void note_input(vsb_pkg::req_t r);
      longint p[3], n[3], w[4], accp[3], accn[3], op[3];
      longint tp, tn, wsum, rn;
      int nb, bone;
      vsb_pkg::rsp_t e;
      if (r.func == vsb_pkg::FUNC_WRITE) begin
        if (r.palette_address < PAL_WORDS) begin
          palette[r.palette_address] = r.palette_value;
          words_written++;
        end
        return;
      end
      nb = bones_cfg < 2 ? 2 : (bones_cfg > 4 ? 4 : int'(bones_cfg));
      p[0] = r.pos_x;
      p[1] = r.pos_y;
      p[2] = r.pos_z;
      for (int c = 0; c < 3; c++) begin
        n[c] = longint'($signed(r.normal_xyz[16*c +: 16]));
        accp[c] = 0;
        accn[c] = 0;
      end
      wsum = 0;
      if (nb == 2) begin
        w[1] = r.weights[15:0];
        w[0] = 32768 - w[1];
      end else begin
        for (int k = 0; k < nb - 1; k++) begin
          w[k] = r.weights[16*k +: 16];
          wsum += w[k];
        end
        w[nb-1] = 32768 - wsum;
      end
      for (int k = 0; k < nb; k++) begin
        bone = r.bone_indices[8*k +: 8] % NBONES;
        for (int c = 0; c < 3; c++) begin
          tp = ((p[0] * word(bone, 0, c)) >>> 16) + ((p[1] * word(bone, 1, c)) >>> 16)
             + ((p[2] * word(bone, 2, c)) >>> 16) + word(bone, 3, c);
          tn = (n[0] * word(bone, 0, c) + n[1] * word(bone, 1, c)
              + n[2] * word(bone, 2, c)) >>> 16;
          tp = clamp(tp, -64'sd2147483648, 64'sd2147483647);
          tn = clamp(tn, -64'sd2147483648, 64'sd2147483647);
          accp[c] += tp * w[k];
          accn[c] += tn * w[k];
        end
      end
      for (int c = 0; c < 3; c++) begin
        op[c] = clamp((accp[c] + 16384) >>> 15, -64'sd2147483648, 64'sd2147483647);
        rn = clamp((accn[c] + 16384) >>> 15, -32768, 32767);
        e.out_normal_xyz[16*c +: 16] = rn[15:0];
      end
      e.out_pos_x = op[0][31:0];
      e.out_pos_y = op[1][31:0];
      e.out_pos_z = op[2][31:0];
      e.out_texcoord = r.texcoord;
      e.out_last = r.last_vertex;
      skinned_q.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // Compare a delivered vertex with the oldest expectation.
    task check_result(vsb_pkg::rsp_t g);
      vsb_pkg::rsp_t e;
      if (skinned_q.size() == 0) begin
        report("unexpected vertex", g.out_pos_x, 0);
        return;
      end
      e = skinned_q.pop_front();
      vertices_checked++;
      if (g.out_pos_x !== e.out_pos_x) report("out_pos_x", g.out_pos_x, e.out_pos_x);
      if (g.out_pos_y !== e.out_pos_y) report("out_pos_y", g.out_pos_y, e.out_pos_y);
      if (g.out_pos_z !== e.out_pos_z) report("out_pos_z", g.out_pos_z, e.out_pos_z);
      if (g.out_normal_xyz !== e.out_normal_xyz)
        report("out_normal_xyz", g.out_normal_xyz, e.out_normal_xyz);
      if (g.out_texcoord !== e.out_texcoord)
        report("out_texcoord", g.out_texcoord, e.out_texcoord);
      if (g.out_last !== e.out_last) report("out_last", g.out_last, e.out_last);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_wdata = 3'd0;
  logic req_valid = 1'b0;
  logic req_ready;
  vsb_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  vsb_pkg::rsp_t rsp;

  skin_scoreboard sb = new();
  bit written[PAL_WORDS];
  bit calm = 1'b0;
  int stall_left = 0;
  int sent = 0;

  vertex_skinning_blend DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #1 clk = ~clk;

  // Sample every handshake at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.set_bones(cfg_wdata);
      if (req_valid && req_ready) sb.note_input(req);
      if (rsp_valid && rsp_ready) sb.check_result(rsp);
    end
  end

  // Mostly short idle runs, now and then a long one; none in a calm stretch.
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side back-pressure.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      stall_left = idle_len();
    end
  end

  task automatic send(input vsb_pkg::req_t item);
    int g;
    bit hit;
    g = idle_len();
    @(negedge clk);
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do begin
      #0.5;
      hit = req_ready;
      @(posedge clk);
    end while (!hit);
    sent++;
  endtask

  // Stop sending and wait until every vertex in flight has been delivered.
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.skinned_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_bones(input bit [2:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic vsb_pkg::req_t noise();
    vsb_pkg::req_t r;
    r.func = vsb_pkg::FUNC_WRITE;
    r.bone_indices = $urandom;
    r.weights = {16'($urandom), 32'($urandom)};
    r.pos_x = $urandom;
    r.pos_y = $urandom;
    r.pos_z = $urandom;
    r.normal_xyz = {16'($urandom), 32'($urandom)};
    r.texcoord = $urandom;
    r.palette_address = 10'($urandom);
    r.palette_value = $urandom;
    r.last_vertex = 1'($urandom);
    return r;
  endfunction

  function automatic int matrix_value();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return int'($urandom_range(0, 262144)) - 131072;
  endfunction

  task automatic write_word(input int addr, input int val);
    vsb_pkg::req_t r;
    r = noise();
    r.func = vsb_pkg::FUNC_WRITE;
    r.palette_address = 10'(addr);
    r.palette_value = val;
    if (addr < PAL_WORDS) written[addr] = 1'b1;
    send(r);
  endtask

  // A bone byte that maps onto a fully loaded matrix, upper bits random.
  function automatic bit [7:0] loaded_bone();
    int b;
    bit ok;
    do begin
      b = $urandom_range(0, NBONES - 1);
      ok = 1'b1;
      for (int i = 0; i < 12; i++) ok &= written[b * 12 + i];
    end while (!ok);
    return 8'(b + NBONES * $urandom_range(0, 3));
  endfunction

  function automatic vsb_pkg::req_t random_vertex();
    vsb_pkg::req_t r;
    int w0, w1, w2;
    r = noise();
    r.func = vsb_pkg::FUNC_SKIN;
    r.bone_indices = {loaded_bone(), loaded_bone(), loaded_bone(), loaded_bone()};
    if ($urandom_range(0, 4) != 0) begin
      w0 = $urandom_range(0, 32768);
      w1 = $urandom_range(0, 32768 - w0);
      w2 = $urandom_range(0, 32768 - w0 - w1);
      r.weights = {16'(w2), 16'(w1), 16'(w0)};
      r.pos_x = int'($urandom_range(0, 2097152)) - 1048576;
      r.pos_y = int'($urandom_range(0, 2097152)) - 1048576;
      r.pos_z = int'($urandom_range(0, 2097152)) - 1048576;
    end
    r.last_vertex = ($urandom_range(0, 7) == 0);
    return r;
  endfunction

  task automatic skin(input bit [31:0] bones, input bit [47:0] wts, input int px,
                      input int py, input int pz, input bit [47:0] nrm, input bit lst);
    vsb_pkg::req_t r;
    r = noise();
    r.func = vsb_pkg::FUNC_SKIN;
    r.bone_indices = bones;
    r.weights = wts;
    r.pos_x = px;
    r.pos_y = py;
    r.pos_z = pz;
    r.normal_xyz = nrm;
    r.texcoord = 32'hffff_ffff;
    r.last_vertex = lst;
    send(r);
  endtask

  initial begin
    bit [2:0] phases[11] = '{3'd3, 3'd4, 3'd0, 3'd1, 3'd5, 3'd6, 3'd7, 3'd2, 3'd4, 3'd3, 3'd2};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Load bones 0 to 7 with ordinary matrices and bone 63 with extreme entries.
    calm = 1'b1;
    for (int a = 0; a < 96; a++) write_word(a, matrix_value());
    for (int i = 0; i < 12; i++)
      write_word(63 * 12 + i, (i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000);
    calm = 1'b0;

    // Directed: writes beyond the palette, and extremes of every vertex field.
    write_word(768, 32'h1234_5678);
    write_word(1023, 32'hffff_ffff);
    skin(32'h0000_0100, 48'h0, 0, 0, 0, 48'h0, 1'b0);
    skin(32'hffff_ffff, 48'hffff_ffff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
         48'h7fff_7fff_7fff, 1'b1);
    skin(32'h0302_c1ff, 48'h8000_8000_8000, 32'sh8000_0000, 32'sh8000_0000,
         32'sh8000_0000, 48'h8000_8000_8000, 1'b0);
    skin(32'h0707_0707, 48'h0000_0000_8000, 32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000,
         48'h4000_c000_4000, 1'b1);
    drain();
    set_bones(3'd4);
    skin(32'hff7f_3f00, 48'h2000_2000_2000, 32'sh7fff_ffff, 32'sh8000_0000, 0,
         48'h7fff_8000_0001, 1'b1);
    skin(32'h0102_0304, 48'hffff_ffff_ffff, 32'sh0010_0000, 32'sh0010_0000, 32'sh0010_0000,
         48'hffff_ffff_ffff, 1'b0);
    drain();

    // Random phases, one bone count per phase including out-of-range codes.
    foreach (phases[ph]) begin
      set_bones(phases[ph]);
      calm = (ph % 4 == 3);
      for (int i = 0; i < 70; i++) begin
        if (i == 35 && ph == 5) drain();
        if ($urandom_range(0, 6) == 0) write_word($urandom_range(0, 1023), matrix_value());
        else send(random_vertex());
      end
      drain();
    end

    $display("Sent %0d transactions: %0d palette words stored, %0d skinned vertices checked.",
             sent, sb.words_written, sb.vertices_checked);
    $display("Bone counts 0 to 7 were each configured, with idle and stall gaps on both sides.");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #4000000;
    $display("Timeout with %0d vertices outstanding.", sb.skinned_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/vsb_pkg.sv
rtl/core/vertex_skinning_blend.sv
tb/vertex_skinning_blend_test.sv
